[hw/rtl/sigmoid_contrast_brightness_unit_assert.svh]
// Assertion macros of the sigmoid contrast and brightness unit.
`ifndef SIGMOID_CONTRAST_BRIGHTNESS_UNIT_ASSERT_SVH
`define SIGMOID_CONTRAST_BRIGHTNESS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define SCB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define SCB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/scb_pkg.sv]
// Package of the sigmoid contrast and brightness unit: types, constants and sigmoid ROM.
package scb_pkg;

  localparam int RomSize  = 768;
  localparam int RomHalf  = 384;
  localparam int StageCnt = 6;
  localparam int AddrW    = 10;

  localparam logic [63:0] Q60One = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } scb_pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } scb_pixel_out_t;

  typedef struct packed {
    logic [7:0] contrast;
    logic [7:0] brightness;
  } scb_cfg_t;

  // Load enables of the six lane stages, stage a in the least significant bit.
  typedef struct packed {
    logic f;
    logic e;
    logic d;
    logic c;
    logic b;
    logic a;
  } scb_stage_en_t;

  typedef enum logic {
    REG_CONTRAST   = 1'b0,
    REG_BRIGHTNESS = 1'b1
  } scb_reg_idx_t;

  typedef logic [RomSize-1:0][15:0] scb_rom_t;

  // Bit-serial long division by a small divisor, used at elaboration only.
  function automatic logic [63:0] scb_div_small(input logic [63:0] num,
                                                input logic [6:0] den);
    logic [63:0] quo;
    logic [70:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[69:0], num[i]};
      if (rem >= 71'(den)) begin
        rem    = rem - 71'(den);
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Truncated Q60 product.
  function automatic logic [63:0] scb_mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'b0, a} * {64'b0, b};
    return prod[123:60];
  endfunction

  // round(65536 / (1 + e)) with e in Q60.
  function automatic logic [16:0] scb_recip_round(input logic [63:0] e);
    logic [63:0] d;
    logic [63:0] rem;
    logic [31:0] q;
    d   = Q60One + e;
    rem = Q60One;
    q   = '0;
    for (int i = 0; i < 17; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= d) begin
        rem  = rem - d;
        q[0] = 1'b1;
      end
    end
    q = (q + 32'd1) >> 1;
    return q[16:0];
  endfunction

  // Sigmoid in Q0.16 over t = -12 .. 12 - 1/32 in steps of 1/32.
  function automatic scb_rom_t scb_build_rom();
    scb_rom_t    rom;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] step;
    logic [63:0] e;
    logic [16:0] v;
    logic [6:0]  n;
    rom  = '0;
    term = Q60One;
    pos  = Q60One;
    neg  = '0;
    // Series of e^(-1/32): each term is the previous one over 32*n.
    for (n = 7'd1; n < 7'd40 && term != 64'd0; n++) begin
      term = scb_div_small(term >> 5, n);
      if (n[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    step = pos - neg;
    e    = Q60One;
    for (int m = 0; m <= RomHalf; m++) begin
      v = scb_recip_round(e);
      if (m < RomHalf) begin
        rom[RomHalf+m] = v[16] ? 16'hFFFF : v[15:0];
      end
      if (m >= 1) begin
        rom[RomHalf-m] = 16'(17'h10000 - v);
      end
      e = scb_mul_q60(e, step);
    end
    return rom;
  endfunction

  localparam scb_rom_t SigRom = scb_build_rom();

endpackage

[hw/rtl/scb_lane.sv]
// One colour channel lane: slope index, sigmoid ROM lookup, gain multiply and saturation.
module scb_lane (
  input  logic                  clk,
  input  scb_pkg::scb_stage_en_t en,
  input  scb_pkg::scb_cfg_t      cfg,
  input  logic [7:0]            pix,
  output logic [7:0]            pix_out
);
  import scb_pkg::*;

  localparam logic [19:0] RecipM     = 20'd954437;
  localparam logic [23:0] DivK       = 24'd4500;
  localparam logic [9:0]  AddrLow    = 10'd128;
  localparam logic [9:0]  AddrHigh   = 10'd895;
  localparam logic [9:0]  AddrMax    = 10'd767;
  localparam logic [16:0] GainBias   = 17'd19661;

  // Stage a: signed distance from mid grey times contrast.
  logic signed [8:0]  diff;
  logic signed [17:0] prod_a;
  logic signed [17:0] prod_a_r;
  logic [7:0]         p_a_r;

  assign diff   = $signed({1'b0, pix}) - 9'sd127;
  assign prod_a = diff * $signed({1'b0, cfg.contrast});

  always_ff @(posedge clk) begin
    if (en.a) begin
      prod_a_r <= prod_a;
      p_a_r    <= pix;
    end
  end

  // Stage b: shift the numerator to be non-negative, estimate the quotient by 4500.
  logic signed [24:0] xs;
  logic [22:0]        x_b;
  logic [42:0]        xm;
  logic [22:0]        x_b_r;
  logic [9:0]         qe_b_r;
  logic [7:0]         p_b_r;

  assign xs  = ($signed({{7{prod_a_r[17]}}, prod_a_r}) <<< 6) + 25'sd2306250;
  assign x_b = xs[22:0];
  assign xm  = 43'(x_b) * 43'(RecipM);

  always_ff @(posedge clk) begin
    if (en.b) begin
      x_b_r  <= x_b;
      qe_b_r <= xm[41:32];
      p_b_r  <= p_a_r;
    end
  end

  // Stage c: correct the estimate by one and clamp to the ROM range.
  logic [23:0] qm;
  logic [22:0] rem_c;
  logic [9:0]  q_c;
  logic [9:0]  addr_c;
  logic [9:0]  addr_c_r;
  logic [7:0]  p_c_r;

  assign qm    = 24'(qe_b_r) * DivK;
  assign rem_c = x_b_r - qm[22:0];
  assign q_c   = qe_b_r + 10'(rem_c >= DivK[22:0]);

  always_comb begin
    priority if (q_c < AddrLow) begin
      addr_c = '0;
    end else if (q_c > AddrHigh) begin
      addr_c = AddrMax;
    end else begin
      addr_c = q_c - AddrLow;
    end
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      addr_c_r <= addr_c;
      p_c_r    <= p_b_r;
    end
  end

  // Stage d: synchronous sigmoid ROM read.
  logic [15:0] rom_d_r;
  logic [7:0]  p_d_r;

  always_ff @(posedge clk) begin
    if (en.d) begin
      rom_d_r <= SigRom[addr_c_r[AddrW-1:0]];
      p_d_r   <= p_c_r;
    end
  end

  // Stage e: pixel times gain.
  logic [16:0] gain_e;
  logic [24:0] mult_e_r;

  assign gain_e = {1'b0, rom_d_r} + GainBias;

  always_ff @(posedge clk) begin
    if (en.e) begin
      mult_e_r <= 25'(p_d_r) * 25'(gain_e);
    end
  end

  // Stage f: brightness offset, rounding and saturation into the output register.
  logic signed [27:0] sum_f;
  logic [7:0]         sat_f;

  assign sum_f = $signed({3'b0, mult_e_r}) + $signed({4'b0, cfg.brightness, 16'b0})
               + 28'sd32768 - 28'sd6553600;

  always_comb begin
    priority if (sum_f[27]) begin
      sat_f = 8'd0;
    end else if (|sum_f[26:24]) begin
      sat_f = 8'hFF;
    end else begin
      sat_f = sum_f[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en.f) begin
      pix_out <= sat_f;
    end
  end

endmodule

[hw/rtl/scb_ctrl.sv]
// Valid tracking and stage load enables for the lane pipeline.
`include "sigmoid_contrast_brightness_unit_assert.svh"

module scb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output scb_pkg::scb_stage_en_t en
);
  import scb_pkg::*;

  logic [StageCnt-1:0] v_r;
  logic [StageCnt-1:0] v_nxt;
  logic [StageCnt-1:0] en_vec;

  // A stage loads when it is empty or its successor loads, so bubbles close up.
  always_comb begin
    en_vec[StageCnt-1] = !v_r[StageCnt-1] || !out_stall;
    for (int i = StageCnt - 2; i >= 0; i--) begin
      en_vec[i] = !v_r[i] || en_vec[i+1];
    end
    v_nxt[0] = en_vec[0] ? in_valid : v_r[0];
    for (int i = 1; i < StageCnt; i++) begin
      v_nxt[i] = en_vec[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign en        = scb_stage_en_t'(en_vec);
  assign in_stall  = !en_vec[0];
  assign out_valid = v_r[StageCnt-1];

  `SCB_ASSERT_IMP(a_empty_front_accepts, !v_r[0], !in_stall, "input stalled with empty front stage")
  `SCB_ASSERT_NXT(a_last_stage_fills, v_r[StageCnt-2] && en_vec[StageCnt-1], out_valid, "item lost before output")
  `SCB_ASSERT_NXT(a_front_holds, v_r[0] && !en_vec[0], v_r[0], "held front item dropped")

endmodule

[hw/rtl/scb_cfg.sv]
// APB register file holding the contrast and brightness settings.
module scb_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output scb_pkg::scb_cfg_t cfg
);
  import scb_pkg::*;

  logic [7:0]   contrast_r;
  logic [7:0]   brightness_r;
  logic         wr_en;
  scb_reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = scb_reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r   <= 8'd20;
      brightness_r <= 8'd100;
    end else if (wr_en) begin
      unique case (idx)
        REG_CONTRAST:   contrast_r   <= pwdata[7:0];
        REG_BRIGHTNESS: brightness_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CONTRAST:   prdata = {24'b0, contrast_r};
      REG_BRIGHTNESS: prdata = {24'b0, brightness_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.contrast   = contrast_r;
  assign cfg.brightness = brightness_r;

endmodule

[hw/rtl/sigmoid_contrast_brightness_unit.sv]
// Top level of the sigmoid contrast and brightness unit.
//
// One RGB pixel per item enters on in_data when in_valid is high and in_stall
// is low; the adjusted pixel leaves on out_data under out_valid and out_stall.
// Three identical lanes, one per colour channel, each run a six-stage pipeline:
// slope product, reciprocal quotient estimate, correction and clamp, sigmoid
// ROM read, gain multiply, and offset with saturation into the output register.
// The output register of the three lanes together forms the result item.
// Throughput is one item per clock while the receiver does not stall, set by
// the fully pipelined lanes with one ROM read port each. When the receiver
// stalls, the items in flight close up behind the output register and input
// is taken until every stage is full. Reset (rst_n low, synchronous) empties
// the pipeline and sets contrast to 20 and brightness to 100. Settings are
// written over the APB port at byte addresses 0 (contrast) and 4 (brightness);
// the user must write them only while the unit is idle, which the block does
// not enforce. pready is always high and reads return the stored values.
module sigmoid_contrast_brightness_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  scb_pkg::scb_pixel_in_t        in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output scb_pkg::scb_pixel_out_t       out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import scb_pkg::*;

  scb_stage_en_t en;
  scb_cfg_t      cfg;
  logic [7:0]    red_q;
  logic [7:0]    green_q;
  logic [7:0]    blue_q;

  scb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  scb_lane u_lane_red (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg),
    .pix     (in_data.red_in),
    .pix_out (red_q)
  );

  scb_lane u_lane_green (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg),
    .pix     (in_data.green_in),
    .pix_out (green_q)
  );

  scb_lane u_lane_blue (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg),
    .pix     (in_data.blue_in),
    .pix_out (blue_q)
  );

  // The lanes finish together, so their output registers make one item.
  always_comb begin
    out_data.red_out   = red_q;
    out_data.green_out = green_q;
    out_data.blue_out  = blue_q;
  end

endmodule
